// ----- rtl/gcb_pkg.sv -----
// ----------------------------------------------------------------------------
// gcb_pkg
// Shared types and constants for the greedy change breakdown block.
// ----------------------------------------------------------------------------
package gcb_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int VAL_W       = 31;
    localparam int ACT_W       = 2;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    // Action codes of an input item
    localparam logic [ACT_W-1:0] ACT_LOAD     = 2'd0;
    localparam logic [ACT_W-1:0] ACT_CLEAR    = 2'd1;
    localparam logic [ACT_W-1:0] ACT_WITHDRAW = 2'd2;

    typedef struct packed {
        logic [ACT_W-1:0] action;
        logic [VAL_W-1:0] value;
    } in_item_t;

    typedef struct packed {
        logic [VAL_W-1:0] denomination;
        logic [VAL_W-1:0] note_count;
        logic [VAL_W-1:0] unpaid;
        logic             last;
    } out_item_t;

    typedef enum logic [1:0] {
        OP_LOAD,
        OP_CLEAR,
        OP_WITHDRAW
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t          op;
        logic [VAL_W-1:0] value;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

// ----- rtl/gcb_front.sv -----
// ----------------------------------------------------------------------------
// gcb_front
// Accepts input items, drops those with no effect and tags the rest as
// commands for the command queue.
// ----------------------------------------------------------------------------
module gcb_front
    import gcb_pkg::*;
(
    input  logic      in_valid,
    output logic      in_stall,
    input  in_item_t  in_data,
    input  q_status_t q_stat,
    output logic      push,
    output cmd_t      push_cmd
);

    logic keep;

    always_comb
    begin
        keep           = 1'b0;
        push_cmd.op    = OP_LOAD;
        push_cmd.value = in_data.value;
        case (in_data.action)
            ACT_LOAD:
            begin
                // a zero denomination never enters the table
                keep        = (in_data.value != '0);
                push_cmd.op = OP_LOAD;
            end
            ACT_CLEAR:
            begin
                keep        = 1'b1;
                push_cmd.op = OP_CLEAR;
            end
            ACT_WITHDRAW:
            begin
                keep        = 1'b1;
                push_cmd.op = OP_WITHDRAW;
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

    assign in_stall = q_stat.full;
    assign push     = in_valid && !q_stat.full && keep;

endmodule

// ----- rtl/gcb_queue.sv -----
// ----------------------------------------------------------------------------
// gcb_queue
// Two-entry command queue between the front and back parts.
// ----------------------------------------------------------------------------
module gcb_queue
    import gcb_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  cmd_t      push_cmd,
    input  logic      pop,
    output cmd_t      head,
    output q_status_t q_stat
);

    cmd_t       entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] fill_reg;

    logic do_push;
    logic do_pop;

    assign do_push = push && (fill_reg != 2'd2);
    assign do_pop  = pop && (fill_reg != 2'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (do_push && !do_pop)
            begin
                fill_reg <= fill_reg + 2'd1;
            end
            else if (do_pop && !do_push)
            begin
                fill_reg <= fill_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    assign head         = entry_reg[rd_ptr_reg];
    assign q_stat.full  = (fill_reg == 2'd2);
    assign q_stat.empty = (fill_reg == 2'd0);

endmodule

// ----- rtl/gcb_back.sv -----
// ----------------------------------------------------------------------------
// gcb_back
// Executes commands: sorted insert into the denomination table, clear, and
// the greedy walk with a bit-serial restoring divider per denomination.
// ----------------------------------------------------------------------------
module gcb_back
    import gcb_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  q_status_t q_stat,
    input  cmd_t      head,
    output logic      pop,
    output logic      out_valid,
    input  logic      out_stall,
    output out_item_t out_data
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INS_CMP,
        ST_INS_SHIFT,
        ST_DIV,
        ST_EMIT
    } state_t;

    localparam logic [4:0] DIV_LAST = 5'(VAL_W - 1);

    state_t                 state_reg,   state_next;
    logic [CNT_W-1:0]       count_reg,   count_next;
    logic [IDX_W-1:0]       idx_reg,     idx_next;
    logic [VAL_W-1:0]       val_reg,     val_next;
    logic [VAL_W-1:0]       d_reg,       d_next;
    logic [VAL_W-1:0]       rem_reg,     rem_next;
    logic [VAL_W-1:0]       quo_reg,     quo_next;
    logic [4:0]             step_reg,    step_next;
    logic [TABLE_DEPTH-1:0] mask_reg,    mask_next;
    logic                   out_valid_reg, out_valid_next;
    out_item_t              out_data_reg,  out_data_next;

    logic [VAL_W-1:0] table_reg  [TABLE_DEPTH];
    logic [VAL_W-1:0] table_next [TABLE_DEPTH];

    logic [VAL_W:0]   shifted;
    logic             fits;
    logic             is_last;
    logic             slot_free;

    // one restoring division step
    assign shifted   = {rem_reg, quo_reg[VAL_W-1]};
    assign fits      = (shifted >= {1'b0, d_reg});
    assign is_last   = (count_reg == '0)
                    || ((CNT_W'({1'b0, idx_reg}) + CNT_W'(1)) == count_reg);
    assign slot_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        val_next       = val_reg;
        d_next         = d_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        step_next      = step_reg;
        mask_next      = mask_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        pop            = 1'b0;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (!q_stat.empty)
                begin
                    pop = 1'b1;
                    case (head.op)
                        OP_LOAD:
                        begin
                            val_next = head.value;
                            // drop a load into a full table
                            if (count_reg != CNT_W'(TABLE_DEPTH))
                            begin
                                state_next = ST_INS_CMP;
                            end
                        end
                        OP_CLEAR:
                        begin
                            count_next = '0;
                        end
                        OP_WITHDRAW:
                        begin
                            idx_next = '0;
                            if (count_reg == '0)
                            begin
                                d_next     = '0;
                                quo_next   = '0;
                                rem_next   = head.value;
                                state_next = ST_EMIT;
                            end
                            else
                            begin
                                d_next     = table_reg[0];
                                quo_next   = head.value;
                                rem_next   = '0;
                                step_next  = '0;
                                state_next = ST_DIV;
                            end
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_INS_CMP:
            begin
                for (int k = 0; k < TABLE_DEPTH; k++)
                begin
                    mask_next[k] = (CNT_W'(k) < count_reg) && (table_reg[k] >= val_reg);
                end
                state_next = ST_INS_SHIFT;
            end
            ST_INS_SHIFT:
            begin
                count_next = count_reg + CNT_W'(1);
                state_next = ST_IDLE;
            end
            ST_DIV:
            begin
                quo_next = {quo_reg[VAL_W-2:0], fits};
                rem_next = fits ? VAL_W'(shifted - {1'b0, d_reg}) : shifted[VAL_W-1:0];
                step_next = step_reg + 5'd1;
                if (step_reg == DIV_LAST)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (slot_free)
                begin
                    out_valid_next             = 1'b1;
                    out_data_next.denomination = d_reg;
                    out_data_next.note_count   = quo_reg;
                    out_data_next.unpaid       = rem_reg;
                    out_data_next.last         = is_last;
                    if (is_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        // advance to the next denomination with what is left
                        idx_next   = idx_reg + IDX_W'(1);
                        d_next     = table_reg[idx_reg + IDX_W'(1)];
                        quo_next   = rem_reg;
                        rem_next   = '0;
                        step_next  = '0;
                        state_next = ST_DIV;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // insert: entries at or above the new value hold, the first lower one
    // takes the new value, the rest move down one place
    always_comb
    begin
        for (int k = 0; k < TABLE_DEPTH; k++)
        begin
            table_next[k] = table_reg[k];
        end
        if (state_reg == ST_INS_SHIFT)
        begin
            if (!mask_reg[0])
            begin
                table_next[0] = val_reg;
            end
            for (int k = 1; k < TABLE_DEPTH; k++)
            begin
                if (!mask_reg[k])
                begin
                    table_next[k] = mask_reg[k-1] ? val_reg : table_reg[k-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < TABLE_DEPTH; k++)
        begin
            table_reg[k] <= table_next[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            idx_reg       <= '0;
            val_reg       <= '0;
            d_reg         <= '0;
            rem_reg       <= '0;
            quo_reg       <= '0;
            step_reg      <= '0;
            mask_reg      <= '0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            val_reg       <= val_next;
            d_reg         <= d_next;
            rem_reg       <= rem_next;
            quo_reg       <= quo_next;
            step_reg      <= step_next;
            mask_reg      <= mask_next;
            out_valid_reg <= out_valid_next;
            out_data_reg  <= out_data_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ----- rtl/greedy_change_breakdown_core.sv -----
// ----------------------------------------------------------------------------
// greedy_change_breakdown_core
// Greedy change breakdown over a sorted table of note denominations.
// ----------------------------------------------------------------------------
// A load runs a pick-up, a compare and a shift step in the back part, a
// clear only a pick-up; a withdrawal that reaches the head of the queue
// with the back part idle runs a pick-up, 31 divide steps and an output
// load. Each further denomination adds 31 divide steps and an output load,
// with the bit-serial divider giving one quotient bit a cycle; output stalls
// add to this, and no new command starts until the last result is loaded.
// Input transfers continue into a two-entry queue while the back part works.
// Reset (rst_n low, asynchronous) empties the table, the queue and the
// output register; table contents stay undefined until loaded.
// ----------------------------------------------------------------------------
module greedy_change_breakdown_core
    import gcb_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  in_item_t  in_data,
    output logic      out_valid,
    input  logic      out_stall,
    output out_item_t out_data
);

    q_status_t q_stat;
    logic      push;
    cmd_t      push_cmd;
    logic      pop;
    cmd_t      head;

    // Front: take a transfer, drop items with no effect, queue the rest
    gcb_front u_front (
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .q_stat   (q_stat),
        .push     (push),
        .push_cmd (push_cmd)
    );

    // Queue: decouple acceptance from execution
    gcb_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .q_stat   (q_stat)
    );

    // Back: hold the table, run inserts and the greedy division walk
    gcb_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_stat    (q_stat),
        .head      (head),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule
